// ----- hw/rtl/kvat_pkg.sv -----
// Shared types and character constants for the key/value assignment tokenizer.
package kvat_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned RoleW = 2;

  // Byte role codes
  localparam logic [RoleW-1:0] ROLE_SKIP  = 2'd0;
  localparam logic [RoleW-1:0] ROLE_NAME  = 2'd1;
  localparam logic [RoleW-1:0] ROLE_VALUE = 2'd2;

  // Characters of interest
  localparam logic [CharW-1:0] CH_NUL    = 8'h00;
  localparam logic [CharW-1:0] CH_TAB    = 8'h09;
  localparam logic [CharW-1:0] CH_SPACE  = 8'h20;
  localparam logic [CharW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CharW-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CharW-1:0] CH_COLON  = 8'h3A;
  localparam logic [CharW-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CharW-1:0] CH_EQUAL  = 8'h3D;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_NAME     = 3'd1,
    PH_OPERATOR = 3'd2,
    PH_VSPACE   = 3'd3,
    PH_VALUE    = 3'd4,
    PH_QUOTED   = 3'd5,
    PH_FIELDSEP = 3'd6,
    PH_DISCARD  = 3'd7
  } phase_e;

  typedef struct packed {
    logic [RoleW-1:0] role;
    logic             pair_end;
    logic             finished;
    logic             accepted;
  } result_t;

endpackage

// ----- hw/rtl/kvat_decode.sv -----
// Single-byte tokenizer decode: next phase and result flags from phase and byte.
module kvat_decode import kvat_pkg::*; (
  input  phase_e           phase_i,
  input  logic [CharW-1:0] char_i,
  output phase_e           phase_o,
  output result_t          res_o
);

  logic is_nul;
  logic is_sp;
  logic is_op;
  logic is_sep;
  logic is_sq;

  assign is_nul = (char_i == CH_NUL);
  assign is_sp  = (char_i == CH_SPACE) || (char_i == CH_TAB);
  assign is_op  = (char_i == CH_EQUAL) || (char_i == CH_COLON);
  assign is_sep = (char_i inside {CH_SEMI, CH_COMMA});
  assign is_sq  = (char_i == CH_SQUOTE);

  // Moves that consume no byte (start->name->operator, vspace->value) are
  // folded into their targets.
  always_comb begin
    res_o   = '0;
    phase_o = phase_i;
    case (phase_i)
      PH_START: begin
        if (is_nul) begin
          res_o.finished = 1'b1;
          res_o.accepted = 1'b1;
        end else if (char_i == CH_DQUOTE) begin
          res_o.finished = 1'b1;
          phase_o        = PH_DISCARD;
        end else if (is_sp) begin
          phase_o = PH_START;
        end else if (is_op) begin
          phase_o = PH_VSPACE;
        end else begin
          res_o.role = ROLE_NAME;
          phase_o    = PH_NAME;
        end
      end
      PH_NAME: begin
        if (is_nul) begin
          res_o.finished = 1'b1;
          phase_o        = PH_START;
        end else if (is_op) begin
          phase_o = PH_VSPACE;
        end else if (char_i == CH_SPACE) begin
          phase_o = PH_OPERATOR;
        end else begin
          res_o.role = ROLE_NAME;
        end
      end
      PH_OPERATOR: begin
        if (is_nul) begin
          res_o.finished = 1'b1;
          phase_o        = PH_START;
        end else if (is_op) begin
          phase_o = PH_VSPACE;
        end
      end
      PH_VSPACE: begin
        if (is_nul) begin
          res_o.finished = 1'b1;
          phase_o        = PH_START;
        end else if (is_sp) begin
          phase_o = PH_VSPACE;
        end else if (is_sep) begin
          res_o.pair_end = 1'b1;
          phase_o        = PH_START;
        end else if (is_sq) begin
          phase_o = PH_QUOTED;
        end else begin
          res_o.role = ROLE_VALUE;
          phase_o    = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_nul) begin
          res_o.pair_end = 1'b1;
          res_o.finished = 1'b1;
          res_o.accepted = 1'b1;
          phase_o        = PH_START;
        end else if (is_sep) begin
          res_o.pair_end = 1'b1;
          phase_o        = PH_START;
        end else if (is_sq) begin
          phase_o = PH_QUOTED;
        end else begin
          res_o.role = ROLE_VALUE;
        end
      end
      PH_QUOTED: begin
        if (is_nul) begin
          res_o.finished = 1'b1;
          phase_o        = PH_START;
        end else if (is_sq) begin
          res_o.pair_end = 1'b1;
          phase_o        = PH_FIELDSEP;
        end else begin
          res_o.role = ROLE_VALUE;
        end
      end
      PH_FIELDSEP: begin
        if (is_nul) begin
          res_o.finished = 1'b1;
          res_o.accepted = 1'b1;
          phase_o        = PH_START;
        end else if (char_i == CH_SPACE) begin
          phase_o = PH_FIELDSEP;
        end else if (is_sep) begin
          phase_o = PH_START;
        end else begin
          res_o.finished = 1'b1;
          phase_o        = PH_DISCARD;
        end
      end
      PH_DISCARD: begin
        if (is_nul) begin
          phase_o = PH_START;
        end
      end
      default: begin
        phase_o = PH_START;
      end
    endcase
  end

endmodule

// ----- hw/rtl/key_value_assignment_tokenizer_core.sv -----
// Top level of the key/value assignment tokenizer: input register, decode, result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | char_in_i[7:0]
//   out     | source    | out_valid_o / out_stall_i | role_o[1:0], pair_end_o, finished_o,
//           |           |                           | accepted_o
//
// One item per clock while out_stall_i is low; an accepted input passes through the input register
// and is then decoded into the result register.
// The phase advances as an item moves into the result register, so
// back-to-back bytes always see the updated phase.
// Reset returns the phase to start and empties both registers.
// An output stall holds the result; the input stalls only while both registers are full.
module key_value_assignment_tokenizer_core import kvat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] char_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RoleW-1:0] role_o,
  output logic             pair_end_o,
  output logic             finished_o,
  output logic             accepted_o
);

  logic             in_vld_q;
  logic [CharW-1:0] char_q;
  logic             out_vld_q;
  result_t          res_q;
  phase_e           phase_q;

  phase_e  phase_d;
  result_t res_d;
  logic    out_free;
  logic    move;

  // Result register can take a new item when empty or being drained.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign move       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  kvat_decode u_decode (
    .phase_i (phase_q),
    .char_i  (char_q),
    .phase_o (phase_d),
    .res_o   (res_d)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_START;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (move) begin
        phase_q <= phase_d;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_in_i;
    end
    if (move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign role_o      = res_q.role;
  assign pair_end_o  = res_q.pair_end;
  assign finished_o  = res_q.finished;
  assign accepted_o  = res_q.accepted;

endmodule

// ----- hw/rtl/kvat_checker.sv -----
// Port-level assertions for the tokenizer, bound to the top level.
module kvat_checker import kvat_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_i,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input logic [RoleW-1:0] role_i,
  input logic             pair_end_i,
  input logic             finished_i,
  input logic             accepted_i
);

  // accept only ever comes with end of string
  a_acc_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!accepted_i || finished_i))
    else $error("accepted without finished");

  // pair completion byte is never tagged as name/value
  a_pair_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && pair_end_i) |-> (role_i == ROLE_SKIP))
    else $error("pair_end on tagged byte");

  // end-of-string byte is never tagged as name/value
  a_fin_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && finished_i) |-> (role_i == ROLE_SKIP))
    else $error("finished on tagged byte");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=>
      (out_valid_i && $stable(role_i) && $stable(pair_end_i) &&
       $stable(finished_i) && $stable(accepted_i)))
    else $error("stalled result changed");

  // an accepted item shows up on the output
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |-> ##2 out_valid_i)
    else $error("accepted item never reached the output");

endmodule

bind key_value_assignment_tokenizer_core kvat_checker u_kvat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .role_i      (role_o),
  .pair_end_i  (pair_end_o),
  .finished_i  (finished_o),
  .accepted_i  (accepted_o)
);

// ----- tb/sv/key_value_assignment_tokenizer_core_tb.sv -----
// Self-checking testbench for the key/value assignment tokenizer core.
`timescale 1ns / 100ps

module key_value_assignment_tokenizer_core_tb;
  import kvat_pkg::*;

  localparam int unsigned DirRows     = 25;
  localparam int unsigned RandItems   = 1200;
  localparam int unsigned PressAfter  = 300;     // results seen before the long hold-off
  localparam int unsigned PressCycles = 300;     // length of the long hold-off
  localparam int unsigned DrainCycles = 16;      // drain wait after the last expected result
  localparam int unsigned CycleLimit  = 500_000;
  localparam int unsigned ShowLimit   = 10;

  // Byte classes used when composing random strings
  typedef enum int unsigned {
    BC_LEAD,    // first byte of a name
    BC_NAME,    // later name byte
    BC_PLAIN,   // unquoted value byte
    BC_QUOTED   // byte inside single quotes
  } byte_class_e;

  // Shapes of random strings
  typedef enum int unsigned {
    SH_CLEAN,
    SH_BROKEN,
    SH_NOISE
  } shape_e;

  typedef struct {
    logic [CharW-1:0] ch;
    bit               typed;   // want holds a hand-written expectation
    result_t          want;
  } byte_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  logic [CharW-1:0] char_in;
  logic             out_valid;
  logic             out_stall;
  logic [RoleW-1:0] role;
  logic             pair_end;
  logic             finished;
  logic             accepted;

  key_value_assignment_tokenizer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .char_in_i   (char_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .role_o      (role),
    .pair_end_o  (pair_end),
    .finished_o  (finished),
    .accepted_o  (accepted)
  );

  // Directed bytes. Row layout: {typed, char, role, pair_end, finished, accepted}.
  // Untyped rows are checked against the predictor only.
  logic [13:0] directed_rows [DirRows] = '{
    {1'b1, CH_NUL,    ROLE_SKIP, 3'b011},   // empty string is accepted
    {1'b1, CH_DQUOTE, ROLE_SKIP, 3'b010},   // double quote at start rejects
    {1'b1, 8'hFF,     ROLE_SKIP, 3'b000},   // swallowed while discarding
    {1'b1, CH_NUL,    ROLE_SKIP, 3'b000},   // zero byte ends the discard silently
    {1'b0, CH_SPACE,  5'b0},                // leading blank skipped
    {1'b1, 8'hFF,     ROLE_NAME, 3'b000},   // top byte value as a name char
    {1'b0, CH_TAB,    5'b0},                // tab is a name char inside a name
    {1'b0, CH_SPACE,  5'b0},                // name -> operator, blank skipped
    {1'b0, CH_COLON,  5'b0},                // colon as the operator
    {1'b0, CH_TAB,    5'b0},                // blank before value
    {1'b0, 8'h76,     5'b0},                // 'v'
    {1'b0, CH_SEMI,   5'b0},                // pair ends, back to start
    {1'b0, 8'h6B,     5'b0},                // 'k'
    {1'b0, CH_EQUAL,  5'b0},                // name -> operator -> equal consumed
    {1'b0, CH_SQUOTE, 5'b0},                // opens quoted value
    {1'b0, 8'h78,     5'b0},                // 'x'
    {1'b0, CH_SQUOTE, 5'b0},                // closing quote ends the pair
    {1'b0, CH_SPACE,  5'b0},                // blank after quoted value
    {1'b0, CH_COMMA,  5'b0},                // field separator
    {1'b0, 8'h61,     5'b0},                // 'a'
    {1'b0, CH_EQUAL,  5'b0},
    {1'b0, 8'h7A,     5'b0},                // 'z'
    {1'b1, CH_NUL,    ROLE_SKIP, 3'b111},   // zero byte closes pair and accepts
    {1'b0, 8'h71,     5'b0},                // 'q'
    {1'b1, CH_NUL,    ROLE_SKIP, 3'b010}    // zero byte inside a name rejects
  };

  byte_row_t        byte_plan[$];     // bytes still to offer
  result_t          awaited_tags[$];  // predicted tags, oldest first
  logic [CharW-1:0] text[$];          // scratch string under construction
  phase_e           tok_phase = PH_START;
  int unsigned      fail_count = 0;
  int unsigned      cycle_count = 0;
  bit               plan_sent = 1'b0;
  bit               squeeze = 1'b0;   // receiver is in its long hold-off

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit is_blank(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic bit is_sep(input logic [CharW-1:0] c);
    return (c == CH_SEMI) || (c == CH_COMMA);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: tags one byte and advances the tokenizer phase. Moves that
  // consume no byte loop back through the case until a phase settles.
  // ---------------------------------------------------------------------------
  function automatic result_t tokenize_byte(input logic [CharW-1:0] ch);
    result_t tag;
    bit      settled;
    tag     = '0;
    settled = 1'b0;
    while (!settled) begin
      settled = 1'b1;
      case (tok_phase)
        PH_START: begin
          if (ch == CH_NUL) begin
            tag.finished = 1'b1;
            tag.accepted = 1'b1;
          end else if (ch == CH_DQUOTE) begin
            tag.finished = 1'b1;
            tok_phase    = PH_DISCARD;
          end else if (!is_blank(ch)) begin
            tok_phase = PH_NAME;
            settled   = 1'b0;
          end
        end
        PH_NAME: begin
          if (ch == CH_NUL) begin
            tag.finished = 1'b1;
            tok_phase    = PH_START;
          end else if (ch == CH_SPACE || ch == CH_EQUAL || ch == CH_COLON) begin
            tok_phase = PH_OPERATOR;
            settled   = 1'b0;
          end else begin
            tag.role = ROLE_NAME;
          end
        end
        PH_OPERATOR: begin
          if (ch == CH_NUL) begin
            tag.finished = 1'b1;
            tok_phase    = PH_START;
          end else if (ch == CH_EQUAL || ch == CH_COLON) begin
            tok_phase = PH_VSPACE;
          end
        end
        PH_VSPACE: begin
          if (ch == CH_NUL) begin
            tag.finished = 1'b1;
            tok_phase    = PH_START;
          end else if (!is_blank(ch)) begin
            tok_phase = PH_VALUE;
            settled   = 1'b0;
          end
        end
        PH_VALUE: begin
          if (ch == CH_NUL) begin
            tag.pair_end = 1'b1;
            tag.finished = 1'b1;
            tag.accepted = 1'b1;
            tok_phase    = PH_START;
          end else if (is_sep(ch)) begin
            tag.pair_end = 1'b1;
            tok_phase    = PH_START;
          end else if (ch == CH_SQUOTE) begin
            tok_phase = PH_QUOTED;
          end else begin
            tag.role = ROLE_VALUE;
          end
        end
        PH_QUOTED: begin
          if (ch == CH_NUL) begin
            tag.finished = 1'b1;
            tok_phase    = PH_START;
          end else if (ch == CH_SQUOTE) begin
            tag.pair_end = 1'b1;
            tok_phase    = PH_FIELDSEP;
          end else begin
            tag.role = ROLE_VALUE;
          end
        end
        PH_FIELDSEP: begin
          if (ch == CH_NUL) begin
            tag.finished = 1'b1;
            tag.accepted = 1'b1;
            tok_phase    = PH_START;
          end else if (is_sep(ch)) begin
            tok_phase = PH_START;
          end else if (ch != CH_SPACE) begin
            // anything else after a closing quote is a syntax error
            tag.finished = 1'b1;
            tok_phase    = PH_DISCARD;
          end
        end
        default: begin
          // discard: silent until the zero byte
          if (ch == CH_NUL) tok_phase = PH_START;
        end
      endcase
    end
    return tag;
  endfunction

  // ---------------------------------------------------------------------------
  // Random string composition
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CharW-1:0] blank_byte();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [CharW-1:0] draw_byte(input byte_class_e cls);
    logic [CharW-1:0] c;
    bit               ok;
    c  = '0;
    ok = 1'b0;
    while (!ok) begin
      c = CharW'($urandom_range(1, 255));
      case (cls)
        BC_LEAD:   ok = !is_blank(c) && c != CH_DQUOTE && c != CH_EQUAL && c != CH_COLON;
        BC_NAME:   ok = c != CH_SPACE && c != CH_EQUAL && c != CH_COLON;
        BC_PLAIN:  ok = !is_sep(c) && c != CH_SQUOTE;
        default:   ok = c != CH_SQUOTE;
      endcase
    end
    return c;
  endfunction

  // Half of the noise bytes are the characters the tokenizer cares about.
  function automatic logic [CharW-1:0] noise_byte();
    case ($urandom_range(0, 17))
      0:       return CH_NUL;
      1:       return CH_SPACE;
      2:       return CH_TAB;
      3:       return CH_EQUAL;
      4:       return CH_COLON;
      5:       return CH_SEMI;
      6:       return CH_COMMA;
      7:       return CH_SQUOTE;
      8:       return CH_DQUOTE;
      default: return CharW'($urandom_range(0, 255));
    endcase
  endfunction

  // Appends one byte to the string under construction.
  function automatic void add_char(input logic [CharW-1:0] c);
    text.insert(text.size(), c);
  endfunction

  // A well-formed assignment string with random names and values.
  task automatic compose_clean();
    int unsigned pairs;
    int unsigned p;
    pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    if (pairs == 0) repeat ($urandom_range(0, 2)) add_char(blank_byte());
    for (p = 0; p < pairs; p++) begin
      repeat ($urandom_range(0, 2)) add_char(blank_byte());
      add_char(draw_byte(BC_LEAD));
      repeat ($urandom_range(0, 5)) add_char(draw_byte(BC_NAME));
      repeat ($urandom_range(0, 1)) add_char(CH_SPACE);
      add_char(($urandom_range(0, 1) != 0) ? CH_EQUAL : CH_COLON);
      repeat ($urandom_range(0, 2)) add_char(blank_byte());
      if ($urandom_range(0, 2) == 0) begin
        add_char(CH_SQUOTE);
        repeat ($urandom_range(0, 5)) add_char(draw_byte(BC_QUOTED));
        add_char(CH_SQUOTE);
        repeat ($urandom_range(0, 1)) add_char(CH_SPACE);
      end else begin
        repeat ($urandom_range(1, 6)) add_char(draw_byte(BC_PLAIN));
      end
      // separator between pairs, and now and then a trailing one
      if (p + 1 < pairs || $urandom_range(0, 4) == 0) begin
        add_char(($urandom_range(0, 1) != 0) ? CH_SEMI : CH_COMMA);
      end
    end
    add_char(CH_NUL);
  endtask

  task automatic compose_string(input shape_e shape);
    int unsigned pos;
    case (shape)
      SH_CLEAN: compose_clean();
      SH_BROKEN: begin
        compose_clean();
        pos = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            // cut short: zero byte lands in the middle of the syntax
            while (text.size() > pos) void'(text.pop_back());
            add_char(CH_NUL);
          end
          1: text[pos] = noise_byte();
          default: text.insert(pos, noise_byte());
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 12)) add_char(noise_byte());
        add_char(CH_NUL);
      end
    endcase
    foreach (text[i]) begin
      byte_plan.insert(byte_plan.size(), '{ch: text[i], typed: 1'b0, want: '0});
    end
    text.delete();
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= ShowLimit) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle counter and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("key_value_assignment_tokenizer_core_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte source: directed table first, then random strings. Each accepted
  // byte is run through the predictor; typed rows override its answer.
  // ---------------------------------------------------------------------------
  initial begin : byte_source
    byte_row_t   row;
    result_t     predicted;
    int unsigned r;
    int unsigned gap;
    int unsigned sent;
    bit          calm;
    in_valid <= 1'b0;
    char_in  <= '0;
    sent      = 0;
    calm      = 1'b0;

    foreach (directed_rows[i]) begin
      byte_plan.insert(byte_plan.size(), '{ch:    directed_rows[i][12:5],
                                           typed: directed_rows[i][13],
                                           want:  directed_rows[i][4:0]});
    end
    while (byte_plan.size() < DirRows + RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 70)      compose_string(SH_CLEAN);
      else if (r < 90) compose_string(SH_BROKEN);
      else             compose_string(SH_NOISE);
    end

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    while (byte_plan.size() != 0) begin
      row = byte_plan.pop_front();
      in_valid <= 1'b1;
      char_in  <= row.ch;
      // accepted at the first edge with stall low
      do @(posedge clk_i); while (in_stall);
      predicted = tokenize_byte(row.ch);
      awaited_tags.insert(awaited_tags.size(), row.typed ? row.want : predicted);
      sent++;
      if (sent % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      // keep offering during the receiver hold-off so the core backs up
      gap = (calm || squeeze) ? 0 : idle_len();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid  <= 1'b0;
    plan_sent  = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, one long hold-off, compare against the
  // oldest predicted tag.
  // ---------------------------------------------------------------------------
  initial begin : tag_sink
    result_t     got;
    result_t     want;
    int unsigned stall_left;
    int unsigned taken;
    int unsigned ticks;
    bit          pressed;
    bit          calm;
    out_stall <= 1'b0;
    stall_left = 0;
    taken      = 0;
    ticks      = 0;
    pressed    = 1'b0;
    calm       = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        got = {role, pair_end, finished, accepted};
        taken++;
        if (awaited_tags.size() == 0) begin
          note_failure($sformatf("unexpected result: role=%0d pair_end=%0b finished=%0b accepted=%0b",
                                 got.role, got.pair_end, got.finished, got.accepted));
        end else begin
          want = awaited_tags.pop_front();
          if (got.role !== want.role || got.pair_end !== want.pair_end ||
              got.finished !== want.finished || got.accepted !== want.accepted) begin
            note_failure($sformatf({"result %0d mismatch: expected role=%0d pair_end=%0b ",
                                    "finished=%0b accepted=%0b, got role=%0d pair_end=%0b ",
                                    "finished=%0b accepted=%0b"},
                                   taken, want.role, want.pair_end, want.finished,
                                   want.accepted, got.role, got.pair_end, got.finished,
                                   got.accepted));
          end
        end
      end

      ticks++;
      if (ticks % 128 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!pressed && taken >= PressAfter) begin
        pressed    = 1'b1;
        squeeze    = 1'b1;
        stall_left = PressCycles;
      end else if (stall_left == 0) begin
        squeeze = 1'b0;
        if (!calm) stall_left = idle_len();
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_control
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!plan_sent) @(posedge clk_i);
    while (awaited_tags.size() != 0) @(posedge clk_i);
    // wait out the drain time to catch stray results
    repeat (DrainCycles) @(posedge clk_i);
    if (awaited_tags.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", awaited_tags.size()));
    end
    if (fail_count == 0) begin
      $display("key_value_assignment_tokenizer_core_tb passed");
    end else begin
      $display("key_value_assignment_tokenizer_core_tb failed");
    end
    $finish;
  end

endmodule
